FILE: src/modulate_backward_reduce_top_defines.svh
// assertion macros for the modulate backward reduce block
// used by modulate_backward_reduce_top.sv, no other dependencies
`ifndef MODULATE_BACKWARD_REDUCE_TOP_DEFINES_SVH
`define MODULATE_BACKWARD_REDUCE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent in one cycle implies consequent in the same cycle
`define MBR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbr assertion failed");

// antecedent in one cycle implies consequent in the next cycle
`define MBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbr assertion failed");

`else

`define MBR_ASSERT_SAME(lbl, ante, cons)
`define MBR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: src/mbr_pkg.sv
// shared types and constants for the modulate backward reduce block
// no dependencies
package mbr_pkg;

  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned SCALE_SUM_W = 48;
  localparam int unsigned SHIFT_SUM_W = 32;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned MAX_ROWS    = 4096;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned IN_DATA_W   = 48;
  localparam int unsigned OUT_DATA_W  = 96;

  localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_ENABLE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHIFT_ENABLE   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_WIDTH      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROWS_PER_BATCH = 2'd3;

  localparam logic signed [PROD_W-1:0] GRAD_MAX = 32'sd32767;
  localparam logic signed [PROD_W-1:0] GRAD_MIN = -32'sd32768;

  // position of one item inside the batch
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic last_col;
  } pos_flags_t;

endpackage

FILE: src/modulate_backward_reduce_top.sv
// modulate backward reduce: input gradient and per-column scale/shift sums
// depends on mbr_pkg and modulate_backward_reduce_top_defines.svh
//
//   channel | direction | payload
//   in_     | slave     | tdata: x_value, dy_value, col_scale
//   out_    | master    | tdata: grad_in, grad_scale_sum, grad_shift_sum; tuser/tlast
//   cfg_    | write     | index 0..3, 13-bit data
//
// one item per cycle unless out_tready stalls; stages 1 and 2 feed the output register
// per-column sums live in a MAX_COLUMNS deep memory, one read and one write a cycle
// the memory needs no clearing pass: the first row of each batch overwrites it
// a stall on the output holds every stage; in_tready follows the output register
// reset: enables on, one column, one row, pipeline empty
`include "modulate_backward_reduce_top_defines.svh"

module modulate_backward_reduce_top
  import mbr_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 4096,
  parameter int unsigned FRAC_BITS   = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // x_value [15:0], dy_value [31:16], col_scale [47:32]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // grad_in [15:0], grad_scale_sum [63:16], grad_shift_sum [95:64]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // sums_valid [0]
  output logic                  out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  // configuration
  logic             scale_en_r;
  logic             shift_en_r;
  logic [COL_W-1:0] col_last_r;
  logic [ROW_W-1:0] row_last_r;
  logic [COL_W-1:0] col_last_nxt;
  logic [ROW_W-1:0] row_last_nxt;

  // batch position
  logic [COL_W-1:0] col_pos_r;
  logic [ROW_W-1:0] row_pos_r;
  pos_flags_t       pos_now;

  // column sum memory
  logic [SCALE_SUM_W-1:0] scale_mem [MAX_COLUMNS];
  logic [SHIFT_SUM_W-1:0] shift_mem [MAX_COLUMNS];
  logic [SCALE_SUM_W-1:0] mem_scale_q_r;
  logic [SHIFT_SUM_W-1:0] mem_shift_q_r;

  // stage 1
  logic                     s1_valid_r;
  logic signed [ELEM_W-1:0] s1_x_r;
  logic signed [ELEM_W-1:0] s1_dy_r;
  logic signed [ELEM_W-1:0] s1_sc_r;
  logic [COL_W-1:0]         s1_col_r;
  pos_flags_t               s1_flags_r;
  logic                     s1_byp_r;
  logic [SCALE_SUM_W-1:0]   s1_byp_scale_r;
  logic [SHIFT_SUM_W-1:0]   s1_byp_shift_r;
  logic [SCALE_SUM_W-1:0]   s1_old_scale;
  logic [SHIFT_SUM_W-1:0]   s1_old_shift;
  logic signed [PROD_W-1:0] s1_xdy;
  logic signed [PROD_W-1:0] s1_dysc;
  logic signed [PROD_W-1:0] s1_floor;
  logic signed [ELEM_W-1:0] s1_grad;

  // stage 2
  logic                     s2_valid_r;
  logic signed [PROD_W-1:0] s2_xdy_r;
  logic signed [ELEM_W-1:0] s2_dy_r;
  logic signed [ELEM_W-1:0] s2_grad_r;
  logic [COL_W-1:0]         s2_col_r;
  pos_flags_t               s2_flags_r;
  logic [SCALE_SUM_W-1:0]   s2_old_scale_r;
  logic [SHIFT_SUM_W-1:0]   s2_old_shift_r;
  logic [SCALE_SUM_W-1:0]   scale_sum_nxt;
  logic [SHIFT_SUM_W-1:0]   shift_sum_nxt;

  // output register
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic                    out_user_r;
  logic                    out_last_r;

  logic advance;
  logic accept;
  logic wr_en;

  assign advance = !out_valid_r || out_tready;
  assign accept  = in_tvalid && advance;
  assign wr_en   = s2_valid_r && advance;

  assign in_tready  = advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // clamp geometry writes: zero reads as one, large values saturate
  always_comb begin
    if (cfg_wdata == '0) begin
      col_last_nxt = '0;
      row_last_nxt = '0;
    end else begin
      if (32'(cfg_wdata) > 32'(MAX_COLUMNS)) begin
        col_last_nxt = COL_W'(MAX_COLUMNS - 1);
      end else begin
        col_last_nxt = COL_W'(cfg_wdata - 13'd1);
      end
      if (32'(cfg_wdata) > 32'(MAX_ROWS)) begin
        row_last_nxt = ROW_W'(MAX_ROWS - 1);
      end else begin
        row_last_nxt = ROW_W'(cfg_wdata - 13'd1);
      end
    end
  end

  assign pos_now.first_row = (row_pos_r == '0);
  assign pos_now.last_row  = (row_pos_r == row_last_r);
  assign pos_now.last_col  = (col_pos_r == col_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_en_r <= 1'b1;
      shift_en_r <= 1'b1;
      col_last_r <= '0;
      row_last_r <= '0;
      col_pos_r  <= '0;
      row_pos_r  <= '0;
    end else begin
      if (accept) begin
        if (pos_now.last_col) begin
          col_pos_r <= '0;
          row_pos_r <= pos_now.last_row ? '0 : row_pos_r + ROW_W'(1);
        end else begin
          col_pos_r <= col_pos_r + COL_W'(1);
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SCALE_ENABLE: begin
            scale_en_r <= cfg_wdata[0];
          end
          CFG_SHIFT_ENABLE: begin
            shift_en_r <= cfg_wdata[0];
          end
          CFG_ROW_WIDTH: begin
            col_last_r <= col_last_nxt;
            col_pos_r  <= '0;
            row_pos_r  <= '0;
          end
          CFG_ROWS_PER_BATCH: begin
            row_last_r <= row_last_nxt;
            col_pos_r  <= '0;
            row_pos_r  <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // sum memory: write back from stage 2, registered read on accept
  always_ff @(posedge clk) begin
    if (wr_en) begin
      scale_mem[s2_col_r] <= scale_sum_nxt;
      shift_mem[s2_col_r] <= shift_sum_nxt;
    end
    if (accept) begin
      mem_scale_q_r <= scale_mem[col_pos_r];
      mem_shift_q_r <= shift_mem[col_pos_r];
    end
  end

  // stage 1 payload; the bypass catches a write to the same column at the read edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r         <= $signed(in_tdata[15:0]);
      s1_dy_r        <= $signed(in_tdata[31:16]);
      s1_sc_r        <= $signed(in_tdata[47:32]);
      s1_col_r       <= col_pos_r;
      s1_flags_r     <= pos_now;
      s1_byp_r       <= wr_en && (s2_col_r == col_pos_r);
      s1_byp_scale_r <= scale_sum_nxt;
      s1_byp_shift_r <= shift_sum_nxt;
    end
  end

  assign s1_old_scale = s1_byp_r ? s1_byp_scale_r : mem_scale_q_r;
  assign s1_old_shift = s1_byp_r ? s1_byp_shift_r : mem_shift_q_r;

  assign s1_xdy   = PROD_W'(s1_x_r) * PROD_W'(s1_dy_r);
  assign s1_dysc  = PROD_W'(s1_dy_r) * PROD_W'(s1_sc_r);
  // arithmetic shift rounds toward minus infinity
  assign s1_floor = s1_dysc >>> FRAC_BITS;

  always_comb begin
    if (!scale_en_r) begin
      s1_grad = s1_dy_r;
    end else if (s1_floor > GRAD_MAX) begin
      s1_grad = ELEM_W'(GRAD_MAX);
    end else if (s1_floor < GRAD_MIN) begin
      s1_grad = ELEM_W'(GRAD_MIN);
    end else begin
      s1_grad = ELEM_W'(s1_floor);
    end
  end

  // stage 2 payload; forward the sum written as this item moves up
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_xdy_r   <= s1_xdy;
      s2_dy_r    <= s1_dy_r;
      s2_grad_r  <= s1_grad;
      s2_col_r   <= s1_col_r;
      s2_flags_r <= s1_flags_r;
      if (wr_en && (s2_col_r == s1_col_r)) begin
        s2_old_scale_r <= scale_sum_nxt;
        s2_old_shift_r <= shift_sum_nxt;
      end else begin
        s2_old_scale_r <= s1_old_scale;
        s2_old_shift_r <= s1_old_shift;
      end
    end
  end

  // first row of a batch starts from zero
  always_comb begin
    scale_sum_nxt = s2_flags_r.first_row ? '0 : s2_old_scale_r;
    shift_sum_nxt = s2_flags_r.first_row ? '0 : s2_old_shift_r;
    if (scale_en_r) begin
      scale_sum_nxt = scale_sum_nxt + SCALE_SUM_W'(s2_xdy_r);
    end
    if (shift_en_r) begin
      shift_sum_nxt = shift_sum_nxt + SHIFT_SUM_W'(s2_dy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r[15:0]  <= s2_grad_r;
      out_data_r[63:16] <= (s2_flags_r.last_row && scale_en_r) ? scale_sum_nxt : '0;
      out_data_r[95:64] <= (s2_flags_r.last_row && shift_en_r) ? shift_sum_nxt : '0;
      out_user_r        <= s2_flags_r.last_row;
      out_last_r        <= s2_flags_r.last_row && s2_flags_r.last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_tvalid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  `MBR_ASSERT_SAME(a_col_in_range, 1'b1, col_pos_r <= col_last_r)
  `MBR_ASSERT_SAME(a_last_in_last_row, out_valid_r && out_last_r, out_user_r)
  `MBR_ASSERT_SAME(a_sums_zero_early, out_valid_r && !out_user_r, out_data_r[95:16] == '0)
  `MBR_ASSERT_NEXT(a_stage_moves, s2_valid_r && advance, out_valid_r)

endmodule

FILE: sim/modulate_backward_reduce_tb.sv
// testbench for modulate_backward_reduce_top: drives elements, config writes and random stalls
// a scoreboard class predicts grad_in and the per-column sums; depends on mbr_pkg and the rtl
`timescale 1ns / 1ps

module tb
  import mbr_pkg::*;
();

  localparam int unsigned MAX_COLS       = 4096;
  localparam int unsigned FRAC           = 12;
  localparam int unsigned RANDOM_ITEMS   = 430;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [ELEM_W-1:0]      grad;
    logic                   sums_valid;
    logic [SCALE_SUM_W-1:0] scale_sum;
    logic [SHIFT_SUM_W-1:0] shift_sum;
    logic                   batch_last;
  } grad_result_t;

  class grad_reduce_board;
    bit                     scale_on;
    bit                     shift_on;
    int unsigned            width_reg;
    int unsigned            rows_reg;
    int unsigned            col_pos;
    int unsigned            row_pos;
    logic [SCALE_SUM_W-1:0] scale_acc [MAX_COLS];
    logic [SHIFT_SUM_W-1:0] shift_acc [MAX_COLS];
    grad_result_t           expected_q [$];
    int                     fail_count;

    function new();
      scale_on   = 1'b1;
      shift_on   = 1'b1;
      width_reg  = 1;
      rows_reg   = 1;
      col_pos    = 0;
      row_pos    = 0;
      fail_count = 0;
      foreach (scale_acc[i]) begin
        scale_acc[i] = '0;
        shift_acc[i] = '0;
      end
    endfunction

    // zero means one, anything above the limit saturates
    function int unsigned clamp_geom(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned batch_items();
      return clamp_geom(width_reg, MAX_COLS) * clamp_geom(rows_reg, MAX_ROWS);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SCALE_ENABLE: scale_on = val[0];
        CFG_SHIFT_ENABLE: shift_on = val[0];
        CFG_ROW_WIDTH: begin
          width_reg = val;
          col_pos   = 0;
          row_pos   = 0;
        end
        CFG_ROWS_PER_BATCH: begin
          rows_reg = val;
          col_pos  = 0;
          row_pos  = 0;
        end
        default: ;
      endcase
    endfunction

    function void note_input(logic signed [ELEM_W-1:0] x, logic signed [ELEM_W-1:0] dy,
                             logic signed [ELEM_W-1:0] sc);
      int unsigned  w;
      int unsigned  r;
      bit           last_row;
      bit           last_col;
      longint       g;
      grad_result_t e;
      w        = clamp_geom(width_reg, MAX_COLS);
      r        = clamp_geom(rows_reg, MAX_ROWS);
      last_row = (row_pos + 1 >= r);
      last_col = (col_pos + 1 >= w);
      if (scale_on) begin
        // arithmetic shift of the full product rounds toward minus infinity
        g = (longint'(dy) * longint'(sc)) >>> FRAC;
        if (g > 32767) g = 32767;
        if (g < -32768) g = -32768;
      end else begin
        g = longint'(dy);
      end
      if (row_pos == 0) begin
        scale_acc[col_pos] = '0;
        shift_acc[col_pos] = '0;
      end
      if (scale_on) scale_acc[col_pos] = scale_acc[col_pos] + 48'(longint'(x) * longint'(dy));
      if (shift_on) shift_acc[col_pos] = shift_acc[col_pos] + 32'(longint'(dy));
      e.grad       = g[ELEM_W-1:0];
      e.sums_valid = last_row;
      e.scale_sum  = (last_row && scale_on) ? scale_acc[col_pos] : '0;
      e.shift_sum  = (last_row && shift_on) ? shift_acc[col_pos] : '0;
      e.batch_last = last_row && last_col;
      expected_q.push_back(e);
      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic sums_flag, logic last_flag);
      grad_result_t got;
      grad_result_t e;
      got.grad       = data[15:0];
      got.scale_sum  = data[63:16];
      got.shift_sum  = data[95:64];
      got.sums_valid = sums_flag;
      got.batch_last = last_flag;
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t: item with nothing expected: grad %0d sums_valid %b scale %0d shift %0d last %b",
                 $time, $signed(got.grad), got.sums_valid, $signed(got.scale_sum),
                 $signed(got.shift_sum), got.batch_last);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        fail_count++;
        $display("%0t: mismatch expected grad %0d sums_valid %b scale %0d shift %0d last %b",
                 $time, $signed(e.grad), e.sums_valid, $signed(e.scale_sum),
                 $signed(e.shift_sum), e.batch_last);
        $display("%0t:          actual grad %0d sums_valid %b scale %0d shift %0d last %b",
                 $time, $signed(got.grad), got.sums_valid, $signed(got.scale_sum),
                 $signed(got.shift_sum), got.batch_last);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  grad_reduce_board board = new();
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;

  modulate_backward_reduce_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser, out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("modulate_backward_reduce_top test failed");
        $finish;
      end
    end
  end

  // all tasks are entered and left at a falling edge
  task automatic send_item(logic [15:0] x, logic [15:0] dy, logic [15:0] sc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {sc, dy, x};
    do @(posedge clk); while (!in_tready);
    board.note_input(x, dy, sc);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_idle(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(11))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h1000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned rand_items;
    int unsigned n;
    int unsigned hold_at;
    int unsigned w;
    int unsigned r;
    int unsigned pick;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_SCALE_ENABLE;
    cfg_wdata  = '0;
    rand_items = 0;
    set_idle(25, 49);
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: every element is a one-row batch, sums come back at once
    send_item(16'h7fff, 16'h7fff, 16'h7fff);
    send_item(16'h8000, 16'h8000, 16'h8000);
    send_item(16'h0001, 16'h7fff, 16'h8000);
    send_item(16'h1234, 16'hffff, 16'h0001);
    send_item(16'hffff, 16'h0001, 16'h0001);
    send_item(16'h0800, 16'h1234, 16'h1000);
    send_item(16'h0000, 16'h0000, 16'h0000);
    send_item(16'h7fff, 16'h8000, 16'h1000);
    send_item(16'h8000, 16'h7fff, 16'hffff);
    send_item(16'h5a5a, 16'hffff, 16'hffff);

    // scale path off, zero geometry reads as one
    wait_drained();
    cfg_write(CFG_SCALE_ENABLE, 13'd0);
    cfg_write(CFG_ROW_WIDTH, 13'd0);
    cfg_write(CFG_ROWS_PER_BATCH, 13'd0);
    send_item(16'h7fff, 16'h8000, 16'h7fff);
    send_item(16'h8000, 16'h7fff, 16'h8000);
    send_item(16'h1111, 16'hffff, 16'h2222);

    // shift sums off
    wait_drained();
    cfg_write(CFG_SCALE_ENABLE, 13'd1);
    cfg_write(CFG_SHIFT_ENABLE, 13'd0);
    send_item(16'h8000, 16'h8000, 16'h4000);
    send_item(16'h7fff, 16'h7fff, 16'hc000);
    send_item(16'h0003, 16'hfffd, 16'h0002);

    // two by two batch: first row reports zero sums
    wait_drained();
    cfg_write(CFG_SHIFT_ENABLE, 13'd1);
    cfg_write(CFG_ROW_WIDTH, 13'd2);
    cfg_write(CFG_ROWS_PER_BATCH, 13'd2);
    send_item(16'h7fff, 16'h7fff, 16'h1000);
    send_item(16'h8000, 16'h7fff, 16'h1000);
    send_item(16'h7fff, 16'h7fff, 16'h1000);
    send_item(16'h8000, 16'h8000, 16'h1000);

    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items < 150) set_idle(25, 49);
      else if (rand_items < 300) set_idle(49, 25);
      else set_idle(0, 0);
      wait_drained();
      cfg_write(CFG_SCALE_ENABLE, 13'($urandom_range(3) != 0));
      cfg_write(CFG_SHIFT_ENABLE, 13'($urandom_range(3) != 0));
      if ($urandom_range(4) != 0) begin
        pick = $urandom_range(9);
        w    = $urandom_range(1, 6);
        r    = $urandom_range(1, 5);
        if (pick == 0) w = 0;
        else if (pick == 1) r = 0;
        else if (pick == 2) w = $urandom_range(4097, 8191);
        else if (pick == 3) r = $urandom_range(4097, 8191);
        cfg_write(CFG_ROW_WIDTH, 13'(w));
        cfg_write(CFG_ROWS_PER_BATCH, 13'(r));
        if (pick == 2 || pick == 3) begin
          // huge geometry: a broken batch, cut short by the next geometry write
          n = $urandom_range(5, 30);
        end else begin
          n = board.batch_items() * $urandom_range(1, 3);
          if ($urandom_range(4) == 0) n += $urandom_range(1, board.batch_items());
        end
      end else begin
        // enables only: the current batch carries on
        n = $urandom_range(3, 15);
      end
      hold_at = ($urandom_range(3) == 0) ? $urandom_range(1, n) : n;
      for (int unsigned i = 0; i < n; i++) begin
        if (i == hold_at) wait_drained();
        send_item(rand_elem(), rand_elem(), rand_elem());
      end
      rand_items += n;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (board.fail_count == 0) begin
      $display("modulate_backward_reduce_top test passed");
    end else begin
      $display("modulate_backward_reduce_top test failed");
    end
    $finish;
  end

endmodule
